// File: hw/rtl/hcm_pkg.sv
// shared types and constants for the hebbian co-activation matrix
// no dependencies; used by hcm_weight_store and hebbian_coactivation_matrix
package hcm_pkg;

  // default sizes
  localparam int unsigned FEATURES_DEF   = 64;
  localparam int unsigned LIST_DEPTH_DEF = 64;

  // fixed field widths
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned FEATURE_W  = 6;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned FIRES_W    = 32;
  localparam int unsigned PRESSURE_W = 14;
  localparam int unsigned PAIRS_W    = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned PRESSURE_MAX = 16383;

  // register reset values
  localparam logic [WEIGHT_W-1:0] STRENGTHEN_RST = 8'd16;
  localparam logic [WEIGHT_W-1:0] CEILING_RST    = 8'd255;
  localparam logic [WEIGHT_W-1:0] DECAY_RST      = 8'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PRESENT    = 2'd0,
    ACT_END_WINDOW = 2'd1,
    ACT_QUERY      = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRENGTHEN = 2'd0,
    CFG_CEILING    = 2'd1,
    CFG_DECAY      = 2'd2
  } cfg_idx_e;

  // write-back operation applied by the weight store
  typedef enum logic [1:0] {
    WOP_CLEAR,
    WOP_STRENGTHEN,
    WOP_DECAY
  } wop_e;

  typedef struct packed {
    logic wr;
    wop_e op;
  } wcmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OUTER,
    ST_OUTER_A,
    ST_FIRE,
    ST_PAIR_B,
    ST_PAIR_W,
    ST_DECAY,
    ST_QUERY
  } state_e;

endpackage

// File: hw/rtl/hebbian_coactivation_matrix.sv
// hebbian co-activation matrix: pair weights, firing counts, window list
// depends on hcm_pkg and hcm_weight_store
// present: result in the cycle after the start beat; the unused action gives no result
// query: one weight row word per cycle from the weight memory port
// end window: list reads and firing count updates per listed entry, a strengthen per distinct pair, then a decay sweep
// reset: clearing pass over the weight memory, busy meanwhile
module hebbian_coactivation_matrix #(
  parameter int unsigned FEATURES   = hcm_pkg::FEATURES_DEF,
  parameter int unsigned LIST_DEPTH = hcm_pkg::LIST_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [hcm_pkg::ACTION_W-1:0]   action_i,
  input  logic [hcm_pkg::FEATURE_W-1:0]  feature_i,
  // result strobe
  output logic                           result_valid_o,
  output logic [hcm_pkg::PRESSURE_W-1:0] pressure_o,
  output logic [hcm_pkg::FIRES_W-1:0]    fires_o,
  output logic                           list_overflow_o,
  output logic [hcm_pkg::PAIRS_W-1:0]    pairs_bound_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hcm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hcm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FF    = FEATURES * FEATURES;
  localparam int unsigned FW    = $clog2(FEATURES);
  localparam int unsigned AW    = $clog2(FF);
  localparam int unsigned KW    = $clog2(FF + 1);
  localparam int unsigned QW    = $clog2(FEATURES + 1);
  localparam int unsigned LW    = $clog2(LIST_DEPTH);
  localparam int unsigned LNW   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SW    = $clog2(FEATURES * 255 + 1);
  localparam int unsigned EXT_W = 9;
  localparam int unsigned WW    = hcm_pkg::WEIGHT_W;

  // only the upper triangle (row < column) is stored; the diagonal stays zero
  function automatic logic [AW-1:0] pair_addr(input logic [FW-1:0] x, input logic [FW-1:0] y);
    logic [FW-1:0] lo;
    logic [FW-1:0] hi;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    return AW'(lo * FEATURES + hi);
  endfunction

  // ---------------------------------------------------------------- state
  hcm_pkg::state_e state_q, state_d;

  logic [WW-1:0]               strengthen_q, ceiling_q, decay_q;
  logic [LNW-1:0]              len_q, len_d;
  logic                        ovf_seen_q, ovf_seen_d;
  logic [KW-1:0]               k_q, k_d;          // clear / decay sweep
  logic                        pend_q, pend_d;    // read in flight during a sweep
  logic                        res_valid_q, res_valid_d;

  logic [LNW-1:0]              i_q, i_d, j_q, j_d;
  logic [FW-1:0]               a_q, a_d, f_q, f_d;
  logic [QW-1:0]               q_q, q_d;
  logic [SW-1:0]               sum_q, sum_d;
  logic [AW-1:0]               wa_q, wa_d;
  logic [hcm_pkg::PAIRS_W-1:0] pairs_q, pairs_d;

  logic [hcm_pkg::PRESSURE_W-1:0] pressure_q, pressure_d;
  logic [hcm_pkg::FIRES_W-1:0]    fires_q, fires_d;
  logic                           res_ovf_q, res_ovf_d;
  logic [hcm_pkg::PAIRS_W-1:0]    res_pairs_q, res_pairs_d;

  // ---------------------------------------------------------------- memories
  logic [FW-1:0]              list_mem [LIST_DEPTH];
  logic [FW-1:0]              list_rdata_q;
  logic                       list_re, list_we;
  logic [LW-1:0]              list_raddr;

  logic [hcm_pkg::FIRES_W-1:0] fire_mem [FEATURES];
  logic [hcm_pkg::FIRES_W-1:0] fire_rdata_q;
  logic [hcm_pkg::FIRES_W-1:0] fire_wdata;
  logic                        fire_re, fire_we;
  logic [FW-1:0]               fire_raddr, fire_waddr;

  logic                        w_re;
  logic [AW-1:0]               w_raddr, w_waddr;
  hcm_pkg::wcmd_t              wcmd;
  logic [WW-1:0]               w_rdata;

  // ---------------------------------------------------------------- decode
  logic                 accept;
  logic [EXT_W-1:0]     feat_ext;
  logic                 feat_ok;
  logic [FW-1:0]        f_idx;
  logic                 list_full;
  logic [LNW-1:0]       i_inc, j_inc;
  logic                 i_more, j_more, j_now;
  logic                 same_ab;
  logic                 k_more, q_more;
  logic                 sum_sat;

  assign busy_o      = (state_q != hcm_pkg::ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  assign feat_ext  = EXT_W'(feature_i);
  assign feat_ok   = feat_ext < EXT_W'(FEATURES);
  assign f_idx     = feat_ext[FW-1:0];
  assign list_full = (len_q == LNW'(LIST_DEPTH));

  // pair loop bookkeeping: outer index i, inner index j
  assign i_inc   = i_q + LNW'(1);
  assign j_inc   = j_q + LNW'(1);
  assign i_more  = i_inc < len_q;
  assign j_more  = j_inc < len_q;
  assign j_now   = j_q < len_q;
  assign same_ab = (list_rdata_q == a_q);
  assign k_more  = k_q < KW'(FF);
  assign q_more  = q_q < QW'(FEATURES);
  assign sum_sat = 32'(sum_q) > 32'(hcm_pkg::PRESSURE_MAX);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hcm_pkg::ST_CLEAR: begin
        if (!k_more) begin
          state_d = hcm_pkg::ST_IDLE;
        end
      end
      hcm_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i)
            hcm_pkg::ACT_END_WINDOW: begin
              state_d = (len_q == '0) ? hcm_pkg::ST_DECAY : hcm_pkg::ST_OUTER;
            end
            hcm_pkg::ACT_QUERY: begin
              if (feat_ok) begin
                state_d = hcm_pkg::ST_QUERY;
              end
            end
            default: state_d = hcm_pkg::ST_IDLE;
          endcase
        end
      end
      hcm_pkg::ST_OUTER:   state_d = hcm_pkg::ST_OUTER_A;
      hcm_pkg::ST_OUTER_A: state_d = hcm_pkg::ST_FIRE;
      hcm_pkg::ST_FIRE: begin
        if (j_now) begin
          state_d = hcm_pkg::ST_PAIR_B;
        end else begin
          state_d = i_more ? hcm_pkg::ST_OUTER : hcm_pkg::ST_DECAY;
        end
      end
      hcm_pkg::ST_PAIR_B: begin
        if (!same_ab) begin
          state_d = hcm_pkg::ST_PAIR_W;
        end else if (!j_more) begin
          state_d = i_more ? hcm_pkg::ST_OUTER : hcm_pkg::ST_DECAY;
        end
      end
      hcm_pkg::ST_PAIR_W: begin
        if (j_more) begin
          state_d = hcm_pkg::ST_PAIR_B;
        end else begin
          state_d = i_more ? hcm_pkg::ST_OUTER : hcm_pkg::ST_DECAY;
        end
      end
      hcm_pkg::ST_DECAY: begin
        if (!k_more && !pend_q) begin
          state_d = hcm_pkg::ST_IDLE;
        end
      end
      hcm_pkg::ST_QUERY: begin
        if (!q_more && !pend_q) begin
          state_d = hcm_pkg::ST_IDLE;
        end
      end
      default: state_d = hcm_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath and memory control
  always_comb begin
    len_d       = len_q;
    ovf_seen_d  = ovf_seen_q;
    k_d         = k_q;
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    f_d         = f_q;
    q_d         = q_q;
    sum_d       = sum_q;
    wa_d        = wa_q;
    pairs_d     = pairs_q;
    pressure_d  = pressure_q;
    fires_d     = fires_q;
    res_ovf_d   = res_ovf_q;
    res_pairs_d = res_pairs_q;

    list_re    = 1'b0;
    list_we    = 1'b0;
    list_raddr = i_q[LW-1:0];
    fire_re    = 1'b0;
    fire_raddr = a_q;
    fire_we    = 1'b0;
    fire_waddr = a_q;
    fire_wdata = fire_rdata_q + hcm_pkg::FIRES_W'(1);
    w_re       = 1'b0;
    w_raddr    = wa_q;
    w_waddr    = wa_q;
    wcmd.wr    = 1'b0;
    wcmd.op    = hcm_pkg::WOP_CLEAR;

    case (state_q)
      // zero every weight word, and the firing counts on the way
      hcm_pkg::ST_CLEAR: begin
        if (k_more) begin
          wcmd.wr = 1'b1;
          wcmd.op = hcm_pkg::WOP_CLEAR;
          w_waddr = k_q[AW-1:0];
          k_d     = k_q + KW'(1);
          if (k_q < KW'(FEATURES)) begin
            fire_we    = 1'b1;
            fire_waddr = k_q[FW-1:0];
            fire_wdata = '0;
          end
        end
      end

      hcm_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i)
            hcm_pkg::ACT_PRESENT: begin
              if (feat_ok) begin
                if (!list_full) begin
                  list_we = 1'b1;
                  len_d   = len_q + LNW'(1);
                end else begin
                  ovf_seen_d = 1'b1;
                end
              end
              res_valid_d = 1'b1;
              pressure_d  = '0;
              fires_d     = '0;
              res_ovf_d   = ovf_seen_q || (feat_ok && list_full);
              res_pairs_d = '0;
            end
            hcm_pkg::ACT_END_WINDOW: begin
              i_d     = '0;
              k_d     = '0;
              pend_d  = 1'b0;
              pairs_d = '0;
            end
            hcm_pkg::ACT_QUERY: begin
              if (feat_ok) begin
                fire_re    = 1'b1;
                fire_raddr = f_idx;
                f_d        = f_idx;
                q_d        = '0;
                sum_d      = '0;
                pend_d     = 1'b0;
              end else begin
                // out-of-range feature answers zero at once
                res_valid_d = 1'b1;
                pressure_d  = '0;
                fires_d     = '0;
                res_ovf_d   = ovf_seen_q;
                res_pairs_d = '0;
              end
            end
            default: ;
          endcase
        end
      end

      hcm_pkg::ST_OUTER: begin
        list_re    = 1'b1;
        list_raddr = i_q[LW-1:0];
      end

      // first entry of the pair arrives: fetch its firing count
      hcm_pkg::ST_OUTER_A: begin
        a_d        = list_rdata_q;
        fire_re    = 1'b1;
        fire_raddr = list_rdata_q;
        j_d        = i_inc;
      end

      hcm_pkg::ST_FIRE: begin
        fire_we    = 1'b1;
        fire_waddr = a_q;
        if (j_now) begin
          list_re    = 1'b1;
          list_raddr = j_q[LW-1:0];
        end else begin
          i_d = i_inc;
        end
      end

      // second entry arrives: equal entries form no pair
      hcm_pkg::ST_PAIR_B: begin
        if (!same_ab) begin
          w_re    = 1'b1;
          w_raddr = pair_addr(a_q, list_rdata_q);
          wa_d    = pair_addr(a_q, list_rdata_q);
        end else begin
          j_d = j_inc;
          if (j_more) begin
            list_re    = 1'b1;
            list_raddr = j_inc[LW-1:0];
          end else begin
            i_d = i_inc;
          end
        end
      end

      // saturating strengthen written back by the weight store
      hcm_pkg::ST_PAIR_W: begin
        wcmd.wr = 1'b1;
        wcmd.op = hcm_pkg::WOP_STRENGTHEN;
        w_waddr = wa_q;
        pairs_d = pairs_q + hcm_pkg::PAIRS_W'(1);
        j_d     = j_inc;
        if (j_more) begin
          list_re    = 1'b1;
          list_raddr = j_inc[LW-1:0];
        end else begin
          i_d = i_inc;
        end
      end

      // streaming decay: read word k while word k-1 is written back
      hcm_pkg::ST_DECAY: begin
        if (k_more) begin
          w_re    = 1'b1;
          w_raddr = k_q[AW-1:0];
          wa_d    = k_q[AW-1:0];
          k_d     = k_q + KW'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          wcmd.wr = 1'b1;
          wcmd.op = hcm_pkg::WOP_DECAY;
          w_waddr = wa_q;
        end
        if (!k_more && !pend_q) begin
          res_valid_d = 1'b1;
          pressure_d  = '0;
          fires_d     = '0;
          res_ovf_d   = ovf_seen_q;
          res_pairs_d = pairs_q;
          len_d       = '0;
          ovf_seen_d  = 1'b0;
        end
      end

      // row sum: one weight per cycle, accumulated in the cycle after its read
      hcm_pkg::ST_QUERY: begin
        if (q_more) begin
          w_re    = 1'b1;
          w_raddr = pair_addr(f_q, q_q[FW-1:0]);
          q_d     = q_q + QW'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          sum_d = sum_q + SW'(w_rdata);
        end
        if (!q_more && !pend_q) begin
          res_valid_d = 1'b1;
          pressure_d  = sum_sat ? hcm_pkg::PRESSURE_W'(hcm_pkg::PRESSURE_MAX)
                                : hcm_pkg::PRESSURE_W'(sum_q);
          fires_d     = fire_rdata_q;
          res_ovf_d   = ovf_seen_q;
          res_pairs_d = '0;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hcm_pkg::ST_CLEAR;
      len_q        <= '0;
      ovf_seen_q   <= 1'b0;
      k_q          <= '0;
      pend_q       <= 1'b0;
      res_valid_q  <= 1'b0;
      strengthen_q <= hcm_pkg::STRENGTHEN_RST;
      ceiling_q    <= hcm_pkg::CEILING_RST;
      decay_q      <= hcm_pkg::DECAY_RST;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ovf_seen_q  <= ovf_seen_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      // configuration beats are taken in every cycle
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          hcm_pkg::CFG_STRENGTHEN: strengthen_q <= cfg_data_i;
          hcm_pkg::CFG_CEILING:    ceiling_q    <= cfg_data_i;
          hcm_pkg::CFG_DECAY:      decay_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    a_q         <= a_d;
    f_q         <= f_d;
    q_q         <= q_d;
    sum_q       <= sum_d;
    wa_q        <= wa_d;
    pairs_q     <= pairs_d;
    pressure_q  <= pressure_d;
    fires_q     <= fires_d;
    res_ovf_q   <= res_ovf_d;
    res_pairs_q <= res_pairs_d;
  end

  // window list memory
  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[len_q[LW-1:0]] <= f_idx;
    end
    if (list_re) begin
      list_rdata_q <= list_mem[list_raddr];
    end
  end

  // firing count memory
  always_ff @(posedge clk_i) begin
    if (fire_we) begin
      fire_mem[fire_waddr] <= fire_wdata;
    end
    if (fire_re) begin
      fire_rdata_q <= fire_mem[fire_raddr];
    end
  end

  hcm_weight_store #(
    .FEATURES (FEATURES)
  ) u_weight_store (
    .clk_i             (clk_i),
    .rd_en_i           (w_re),
    .rd_addr_i         (w_raddr),
    .cmd_i             (wcmd),
    .wr_addr_i         (w_waddr),
    .strengthen_step_i (strengthen_q),
    .weight_ceiling_i  (ceiling_q),
    .decay_step_i      (decay_q),
    .rd_data_o         (w_rdata)
  );

  // ---------------------------------------------------------------- outputs
  assign result_valid_o  = res_valid_q;
  assign pressure_o      = pressure_q;
  assign fires_o         = fires_q;
  assign list_overflow_o = res_ovf_q;
  assign pairs_bound_o   = res_pairs_q;

  // ---------------------------------------------------------------- assertions
  // a present beat always produces its result beat in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == hcm_pkg::ACT_PRESENT) |=> result_valid_o)
    else $error("present beat without result");

  // an end-window beat always starts a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == hcm_pkg::ACT_END_WINDOW) |=> busy_o)
    else $error("end window did not start processing");

  // decay write-back never targets the word being read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hcm_pkg::ST_DECAY) && wcmd.wr && w_re |-> (w_waddr != w_raddr))
    else $error("decay read and write collide");

  // the window is empty once an end window finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hcm_pkg::ST_DECAY) && (state_d == hcm_pkg::ST_IDLE)
      |=> (len_q == '0) && !ovf_seen_q)
    else $error("window not emptied at end window");

endmodule

// File: hw/rtl/hcm_weight_store.sv
// link weight memory with its read-modify-write arithmetic
// depends on hcm_pkg
module hcm_weight_store #(
  parameter int unsigned FEATURES = hcm_pkg::FEATURES_DEF,
  localparam int unsigned AW = $clog2(FEATURES * FEATURES)
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  input  hcm_pkg::wcmd_t               cmd_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [hcm_pkg::WEIGHT_W-1:0] strengthen_step_i,
  input  logic [hcm_pkg::WEIGHT_W-1:0] weight_ceiling_i,
  input  logic [hcm_pkg::WEIGHT_W-1:0] decay_step_i,
  output logic [hcm_pkg::WEIGHT_W-1:0] rd_data_o
);

  localparam int unsigned DEPTH = FEATURES * FEATURES;

  logic [hcm_pkg::WEIGHT_W-1:0] mem [DEPTH];
  logic [hcm_pkg::WEIGHT_W-1:0] rd_data_q;
  logic [hcm_pkg::WEIGHT_W:0]   sum_wide;
  logic [hcm_pkg::WEIGHT_W-1:0] strengthened;
  logic [hcm_pkg::WEIGHT_W-1:0] decayed;
  logic [hcm_pkg::WEIGHT_W-1:0] wr_data;

  // strengthen and decay write data derive from the word read in the previous cycle; clear writes zero
  assign sum_wide     = {1'b0, rd_data_q} + {1'b0, strengthen_step_i};
  assign strengthened = (sum_wide > {1'b0, weight_ceiling_i}) ? weight_ceiling_i
                                                               : sum_wide[hcm_pkg::WEIGHT_W-1:0];
  assign decayed      = (rd_data_q > decay_step_i) ? (rd_data_q - decay_step_i) : '0;

  always_comb begin
    case (cmd_i.op)
      hcm_pkg::WOP_CLEAR:      wr_data = '0;
      hcm_pkg::WOP_STRENGTHEN: wr_data = strengthened;
      hcm_pkg::WOP_DECAY:      wr_data = decayed;
      default:                 wr_data = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wr_addr_i] <= wr_data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
